FILE: sv/gai_pkg.sv
// Shared constants, types and a helper function of the gyro angle integrator.
package gai_pkg;

	localparam int WIN_LOG2   = 5;
	localparam int WINDOW_LEN = 1 << WIN_LOG2;
	localparam int SUM_W      = 16 + WIN_LOG2;
	localparam int ANGLE_W    = 29;
	localparam int GAIN_W     = 24;
	localparam int DRIFT_W    = 30;
	localparam int STEP_W     = 23;
	localparam int PROD_W     = 16 + GAIN_W;
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = 3;

	localparam logic [ANGLE_W:0] FULL_TURN   = 30'd360000000;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd5734400;

	localparam logic signed [DRIFT_W:0] TURN_S  = 31'sd360000000;
	localparam logic signed [DRIFT_W:0] TURN2_S = 31'sd720000000;

	typedef enum logic [1:0] {
		REG_RATE_GAIN = 2'd0,
		REG_DRIFT_X   = 2'd1,
		REG_DRIFT_Y   = 2'd2,
		REG_DRIFT_Z   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic acc;
		logic s1;
		logic s2;
	} pipe_ctl_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle_x;
		logic [ANGLE_W-1:0] angle_y;
		logic [ANGLE_W-1:0] angle_z;
		logic [15:0]        accel_x_mean;
		logic [15:0]        accel_z_mean;
	} res_t;

	// Brings a signed drift word into the range of one full turn.
	function automatic logic [ANGLE_W-1:0] reduce_drift(input logic [DRIFT_W-1:0] v);
		logic signed [DRIFT_W:0] s;
		logic signed [DRIFT_W:0] r;
		s = $signed({v[DRIFT_W-1], v});
		if (s < -TURN_S) begin
			r = s + TURN2_S;
		end else if (s < 0) begin
			r = s + TURN_S;
		end else if (s >= TURN_S) begin
			r = s - TURN_S;
		end else begin
			r = s;
		end
		return r[ANGLE_W-1:0];
	endfunction

endpackage

FILE: sv/gai_gyro_lane.sv
// One gyro axis lane: scales the rate, folds in the drift and accumulates the angle.
module gai_gyro_lane (
	input  logic                           clk,
	input  logic                           arst_n,
	input  gai_pkg::pipe_ctl_t             ctl,
	input  logic signed [15:0]             rate,
	input  logic [gai_pkg::GAIN_W-1:0]     gain,
	input  logic [gai_pkg::ANGLE_W-1:0]    drift,
	output logic [gai_pkg::ANGLE_W-1:0]    angle
);

	logic [15:0]                    raw;
	logic [15:0]                    mag;
	logic                           neg;
	logic [gai_pkg::PROD_W-1:0]     prod;
	logic [gai_pkg::STEP_W-1:0]     step_s1;
	logic                           neg_s1;
	logic [gai_pkg::ANGLE_W:0]      pos_sum;
	logic [gai_pkg::ANGLE_W:0]      pos_red;
	logic [gai_pkg::ANGLE_W:0]      neg_dif;
	logic [gai_pkg::ANGLE_W:0]      neg_red;
	logic [gai_pkg::ANGLE_W-1:0]    delta_s2;
	logic [gai_pkg::ANGLE_W:0]      acc_sum;
	logic [gai_pkg::ANGLE_W-1:0]    angle_q;

	// The most negative count is taken as a positive rate of full magnitude.
	assign raw  = $unsigned(rate);
	assign mag  = raw[15] ? 16'(-raw) : raw;
	assign neg  = raw[15] && (raw[14:0] != 15'd0);
	assign prod = {{gai_pkg::GAIN_W{1'b0}}, mag} * {16'd0, gain};

	always_ff @(posedge clk) begin
		if (ctl.acc) begin
			step_s1 <= prod[gai_pkg::STEP_W+15:16];
			neg_s1  <= neg;
		end
	end

	// The signed step and the drift are combined into one forward move.
	always_comb begin
		pos_sum = {1'b0, drift} + {{(gai_pkg::ANGLE_W+1-gai_pkg::STEP_W){1'b0}}, step_s1};
		pos_red = (pos_sum >= gai_pkg::FULL_TURN) ? pos_sum - gai_pkg::FULL_TURN : pos_sum;
		neg_dif = {1'b0, drift} - {{(gai_pkg::ANGLE_W+1-gai_pkg::STEP_W){1'b0}}, step_s1};
		neg_red = neg_dif[gai_pkg::ANGLE_W] ? neg_dif + gai_pkg::FULL_TURN : neg_dif;
	end

	always_ff @(posedge clk) begin
		if (ctl.s1) begin
			delta_s2 <= neg_s1 ? neg_red[gai_pkg::ANGLE_W-1:0] : pos_red[gai_pkg::ANGLE_W-1:0];
		end
	end

	assign acc_sum = {1'b0, angle_q} + {1'b0, delta_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0;
		end else if (ctl.s2) begin
			if (acc_sum >= gai_pkg::FULL_TURN) begin
				angle_q <= 29'(acc_sum - gai_pkg::FULL_TURN);
			end else begin
				angle_q <= acc_sum[gai_pkg::ANGLE_W-1:0];
			end
		end
	end

	assign angle = angle_q;

endmodule

FILE: sv/gai_accel_lane.sv
// One accelerometer lane: a ring of sample magnitudes with a running window sum.
module gai_accel_lane (
	input  logic                            clk,
	input  logic                            arst_n,
	input  gai_pkg::pipe_ctl_t              ctl,
	input  logic signed [15:0]              sample,
	input  logic [gai_pkg::WIN_LOG2-1:0]    slot,
	output logic [15:0]                     mean
);

	logic [15:0]                     raw;
	logic [15:0]                     mag;
	logic [15:0]                     ring [gai_pkg::WINDOW_LEN];
	logic [gai_pkg::WINDOW_LEN-1:0]  vld_q;
	logic [15:0]                     old_s1;
	logic                            old_vld_s1;
	logic [15:0]                     mag_s1;
	logic [gai_pkg::SUM_W-1:0]       sum_q;
	logic [15:0]                     mean_s3;

	assign raw = $unsigned(sample);
	assign mag = raw[15] ? 16'(-raw) : raw;

	always_ff @(posedge clk) begin
		if (ctl.acc) begin
			ring[slot] <= mag;
			old_s1     <= ring[slot];
			mag_s1     <= mag;
		end
	end

	// A slot that was never written counts as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			old_vld_s1 <= 1'b0;
		end else if (ctl.acc) begin
			vld_q[slot] <= 1'b1;
			old_vld_s1  <= vld_q[slot];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.s1) begin
			sum_q <= sum_q - (old_vld_s1 ? gai_pkg::SUM_W'(old_s1) : '0)
				+ gai_pkg::SUM_W'(mag_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.s2) begin
			mean_s3 <= sum_q[gai_pkg::SUM_W-1:gai_pkg::WIN_LOG2];
		end
	end

	assign mean = mean_s3;

endmodule

FILE: sv/gai_merge.sv
// Merging stage: gathers the lane results of one request into a small result queue.
module gai_merge (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  gai_pkg::res_t              push_data,
	input  logic                       pop,
	output gai_pkg::res_t              head,
	output logic [gai_pkg::FIFO_AW:0]  count
);

	gai_pkg::res_t                slots_q [gai_pkg::FIFO_DEPTH];
	logic [gai_pkg::FIFO_AW-1:0]  wr_ptr_q;
	logic [gai_pkg::FIFO_AW-1:0]  rd_ptr_q;
	logic [gai_pkg::FIFO_AW:0]    count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head  = slots_q[rd_ptr_q];
	assign count = count_q;

endmodule

FILE: sv/gyro_angle_integrator_with_accel_mean.sv
// Top level of the gyro angle integrator with accelerometer window means.
// One request is accepted per clock cycle while in_stall is low. Each request
// carries three gyro rates and two accelerometer samples; three gyro lanes and two
// accelerometer lanes work on it side by side, and its result passes through the
// gain multiply register, the drift fold register and the angle accumulator, and
// then through the result queue to the output. The queue holds eight results, so
// requests keep flowing while a result waits; the input stalls only when the queue
// and the lanes together hold eight requests. The window sums cover the last 32
// requests, with slots never written counted as zero.
module gyro_angle_integrator_with_accel_mean (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [1:0]                     cfg_index,
	input  logic [gai_pkg::DRIFT_W-1:0]    cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [15:0]             gyro_rate_x,
	input  logic signed [15:0]             gyro_rate_y,
	input  logic signed [15:0]             gyro_rate_z,
	input  logic signed [15:0]             accel_sample_x,
	input  logic signed [15:0]             accel_sample_z,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [gai_pkg::ANGLE_W-1:0]    angle_x,
	output logic [gai_pkg::ANGLE_W-1:0]    angle_y,
	output logic [gai_pkg::ANGLE_W-1:0]    angle_z,
	output logic [15:0]                    accel_x_mean,
	output logic [15:0]                    accel_z_mean
);

	logic [gai_pkg::GAIN_W-1:0]    gain_q;
	logic [gai_pkg::ANGLE_W-1:0]   drift_x_q;
	logic [gai_pkg::ANGLE_W-1:0]   drift_y_q;
	logic [gai_pkg::ANGLE_W-1:0]   drift_z_q;
	logic [gai_pkg::ANGLE_W-1:0]   drift_red;
	logic [gai_pkg::WIN_LOG2-1:0]  slot_q;
	logic                          acc;
	logic                          v_s1;
	logic                          v_s2;
	logic                          v_s3;
	gai_pkg::pipe_ctl_t            ctl;
	gai_pkg::res_t                 lane_res;
	gai_pkg::res_t                 head;
	logic [gai_pkg::FIFO_AW:0]     count;
	logic [gai_pkg::FIFO_AW+1:0]   occupancy;
	logic                          pop;

	assign drift_red = gai_pkg::reduce_drift(cfg_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q    <= gai_pkg::GAIN_RESET;
			drift_x_q <= '0;
			drift_y_q <= '0;
			drift_z_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (gai_pkg::cfg_reg_t'(cfg_index))
				gai_pkg::REG_RATE_GAIN: gain_q    <= cfg_data[gai_pkg::GAIN_W-1:0];
				gai_pkg::REG_DRIFT_X:   drift_x_q <= drift_red;
				gai_pkg::REG_DRIFT_Y:   drift_y_q <= drift_red;
				gai_pkg::REG_DRIFT_Z:   drift_z_q <= drift_red;
				default: begin
				end
			endcase
		end
	end

	assign occupancy = (gai_pkg::FIFO_AW+2)'(count) + (gai_pkg::FIFO_AW+2)'(v_s1)
		+ (gai_pkg::FIFO_AW+2)'(v_s2) + (gai_pkg::FIFO_AW+2)'(v_s3);
	assign in_stall  = occupancy >= (gai_pkg::FIFO_AW+2)'(gai_pkg::FIFO_DEPTH);
	assign acc       = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			slot_q <= '0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (acc) begin
				slot_q <= slot_q + 1'b1;
			end
		end
	end

	assign ctl.acc = acc;
	assign ctl.s1  = v_s1;
	assign ctl.s2  = v_s2;

	gai_gyro_lane u_gyro_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.rate   (gyro_rate_x),
		.gain   (gain_q),
		.drift  (drift_x_q),
		.angle  (lane_res.angle_x)
	);

	gai_gyro_lane u_gyro_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.rate   (gyro_rate_y),
		.gain   (gain_q),
		.drift  (drift_y_q),
		.angle  (lane_res.angle_y)
	);

	gai_gyro_lane u_gyro_z (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.rate   (gyro_rate_z),
		.gain   (gain_q),
		.drift  (drift_z_q),
		.angle  (lane_res.angle_z)
	);

	gai_accel_lane u_accel_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sample (accel_sample_x),
		.slot   (slot_q),
		.mean   (lane_res.accel_x_mean)
	);

	gai_accel_lane u_accel_z (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sample (accel_sample_z),
		.slot   (slot_q),
		.mean   (lane_res.accel_z_mean)
	);

	assign pop = out_valid && !out_stall;

	gai_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s3),
		.push_data (lane_res),
		.pop       (pop),
		.head      (head),
		.count     (count)
	);

	assign out_valid    = count != '0;
	assign angle_x      = head.angle_x;
	assign angle_y      = head.angle_y;
	assign angle_z      = head.angle_z;
	assign accel_x_mean = head.accel_x_mean;
	assign accel_z_mean = head.accel_z_mean;

endmodule

FILE: sv/gai_checker.sv
// Port-level checker for the gyro angle integrator, bound to the top level.
module gai_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [gai_pkg::ANGLE_W-1:0]    angle_x,
	input  logic [gai_pkg::ANGLE_W-1:0]    angle_y,
	input  logic [gai_pkg::ANGLE_W-1:0]    angle_z,
	input  logic [15:0]                    accel_x_mean,
	input  logic [15:0]                    accel_z_mean
);

	// A request that is accepted has a valid result on the output after the lane registers and the result queue.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> ##4 out_valid)
		else $error("accepted request did not reach the output in time");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (angle_x < 29'd360000000) && (angle_y < 29'd360000000)
			&& (angle_z < 29'd360000000))
		else $error("angle outside one full turn");

	a_mean_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (accel_x_mean <= 16'd32768) && (accel_z_mean <= 16'd32768))
		else $error("window mean above the largest magnitude");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(angle_x) && $stable(accel_x_mean))
		else $error("stalled result changed or was dropped");

endmodule

bind gyro_angle_integrator_with_accel_mean gai_checker u_gai_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.angle_x      (angle_x),
	.angle_y      (angle_y),
	.angle_z      (angle_z),
	.accel_x_mean (accel_x_mean),
	.accel_z_mean (accel_z_mean)
);
